// ----- rtl/prle_pkg.sv -----
package prle_pkg;

	// Default sizes
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_RUN_DEF       = 255;
	localparam int MAX_ROW_WIDTH_DEF = 4096;

	// Fixed field widths
	localparam int RGB_W    = 24;
	localparam int COLOR_W  = 8;
	localparam int LEN_W    = 8;
	localparam int ROWW_W   = 13;
	localparam int PCOUNT_W = 9;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 1'b1;

	// Input item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0]   run_length;
		logic [COLOR_W-1:0] color_number;
		logic               ends_row;
		logic               last;
	} packet_t;

	typedef struct packed {
		logic               done;
		logic [COLOR_W-1:0] color;
	} search_rsp_t;

endpackage

// ----- rtl/palette_run_length_encoder.sv -----
// Channel  Direction  Handshake          Word
// in       sink       in_valid/in_stall   kind, entry_index, rgb_value
// out      source     out_valid/out_stall run_length, color_number, ends_row, last
// cfg      sink       cfg_write           cfg_index, cfg_data
//
// A load word is written into the palette when accepted; a pixel waits on the palette
// search, which reads up to min(palette_count, PALETTE_DEPTH) entries, one per cycle,
// through a single comparator. Up to two result words wait in a two-entry output buffer,
// so the next word is accepted while results are still being drained. A pixel finishes
// only once that buffer is empty. Reset clears run state and sets row_width 1,
// palette_count 0; palette contents are undefined until loaded.
module palette_run_length_encoder #(
	parameter int PALETTE_DEPTH = prle_pkg::PALETTE_DEPTH_DEF,
	parameter int MAX_RUN       = prle_pkg::MAX_RUN_DEF,
	parameter int MAX_ROW_WIDTH = prle_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [7:0]                        entry_index,
	input  logic [prle_pkg::RGB_W-1:0]        rgb_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [prle_pkg::LEN_W-1:0]        run_length,
	output logic [prle_pkg::COLOR_W-1:0]      color_number,
	output logic                              ends_row,
	output logic                              last,
	input  logic                              cfg_write,
	input  logic [prle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prle_pkg::ROWW_W-1:0]       cfg_data
);
	import prle_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int SW = $clog2(PALETTE_DEPTH + 1);
	localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
	localparam int WW = (CW > ROWW_W) ? CW : ROWW_W;

	state_t state_q, state_d;

	logic [ROWW_W-1:0]   row_width_q;
	logic [PCOUNT_W-1:0] palette_count_q;
	logic [COLOR_W-1:0]  cur_color_q;
	logic [LEN_W-1:0]    cur_len_q;
	logic [CW-1:0]       col_q;
	logic [COLOR_W-1:0]  idx_q;

	packet_t    slot0_q, slot1_q;
	logic [1:0] out_cnt_q;

	logic in_acc, out_acc, pix_start, load_we, commit_en;
	logic [SW-1:0]    count_eff;
	logic [RGB_W-1:0] rd_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	search_rsp_t      rsp;

	// Run update signals
	logic              close_old, row_end, run_full, emit_new;
	logic [LEN_W-1:0]  len_a, len_b;
	logic [COLOR_W-1:0] color_a;
	logic [CW-1:0]     col_inc;
	logic [WW-1:0]     row_ext, width_eff;
	packet_t           pkt_old, pkt_new;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign pix_start = in_acc && (kind == KIND_PIXEL);
	assign load_we   = in_acc && (kind == KIND_LOAD) &&
	                   ({1'b0, entry_index} < 9'(PALETTE_DEPTH));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q     <= ROWW_W'(1);
			palette_count_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_WIDTH:     row_width_q     <= cfg_data;
				REG_PALETTE_COUNT: palette_count_q <= cfg_data[PCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective search length
	assign count_eff = (palette_count_q > PCOUNT_W'(PALETTE_DEPTH)) ?
	                   SW'(PALETTE_DEPTH) : SW'(palette_count_q);

	prle_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (load_we),
		.wr_addr (entry_index[AW-1:0]),
		.wr_data (rgb_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	prle_search #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pix_start),
		.rgb_value (rgb_value),
		.count     (count_eff),
		.rd_data   (rd_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rsp       (rsp)
	);

	// FSM next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (pix_start) state_d = ST_SEARCH;
			ST_SEARCH: if (rsp.done) state_d = ST_COMMIT;
			ST_COMMIT: if (out_cnt_q == 2'd0) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_stall  = 1'b1;
		commit_en = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall  = 1'b0;
			ST_SEARCH: in_stall  = 1'b1;
			ST_COMMIT: commit_en = (out_cnt_q == 2'd0);
			default:   in_stall  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.done) begin
			idx_q <= rsp.color;
		end
	end

	// Run bookkeeping
	always_comb begin
		close_old = (cur_len_q != '0) && (idx_q != cur_color_q);
		len_a     = close_old ? '0 : cur_len_q;
		color_a   = (len_a == '0) ? idx_q : cur_color_q;
		len_b     = len_a + 1'b1;

		row_ext   = WW'(row_width_q);
		if (row_ext == '0) begin
			width_eff = WW'(1);
		end else if (row_ext > WW'(MAX_ROW_WIDTH)) begin
			width_eff = WW'(MAX_ROW_WIDTH);
		end else begin
			width_eff = row_ext;
		end

		col_inc  = col_q + 1'b1;
		row_end  = WW'(col_inc) >= width_eff;
		run_full = len_b >= LEN_W'(MAX_RUN);
		emit_new = row_end || run_full;

		pkt_old.run_length   = cur_len_q;
		pkt_old.color_number = cur_color_q;
		pkt_old.ends_row     = 1'b0;
		pkt_old.last         = !emit_new;

		pkt_new.run_length   = len_b;
		pkt_new.color_number = color_a;
		pkt_new.ends_row     = row_end;
		pkt_new.last         = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_color_q <= '0;
			cur_len_q   <= '0;
			col_q       <= '0;
		end else if (commit_en) begin
			cur_color_q <= color_a;
			cur_len_q   <= emit_new ? '0 : len_b;
			col_q       <= row_end ? '0 : col_inc;
		end
	end

	// Two-entry output buffer, slot0 is the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (commit_en) begin
			out_cnt_q <= {1'b0, close_old} + {1'b0, emit_new};
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			slot0_q <= close_old ? pkt_old : pkt_new;
			slot1_q <= pkt_new;
		end else if (out_acc) begin
			slot0_q <= slot1_q;
		end
	end

	assign out_valid    = (out_cnt_q != 2'd0);
	assign run_length   = slot0_q.run_length;
	assign color_number = slot0_q.color_number;
	assign ends_row     = slot0_q.ends_row;
	assign last         = slot0_q.last;

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= 2'd2)
		else $error("output buffer overflow");
	a_run_open_short: assert property (@(posedge clk) disable iff (!arst_n)
		cur_len_q < LEN_W'(MAX_RUN))
		else $error("open run reached full length");
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == ST_SEARCH)
		else $error("search finished outside search state");
	a_word_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("empty run word");

endmodule

// ----- rtl/prle_ram.sv -----
module prle_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/prle_search.sv -----
module prle_search #(
	parameter int PALETTE_DEPTH = prle_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [prle_pkg::RGB_W-1:0]         rgb_value,
	input  logic [$clog2(PALETTE_DEPTH+1)-1:0] count,
	input  logic [prle_pkg::RGB_W-1:0]         rd_data,
	output logic                               rd_en,
	output logic [$clog2(PALETTE_DEPTH)-1:0]   rd_addr,
	output prle_pkg::search_rsp_t              rsp
);
	import prle_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int SW = $clog2(PALETTE_DEPTH + 1);

	logic          busy_q;
	logic [SW-1:0] issue_q;
	logic [SW-1:0] count_q;
	logic [RGB_W-1:0] rgb_q;
	logic          cmp_valid_s1;
	logic [AW-1:0] cmp_idx_s1;
	logic          hit;

	// Read issue: one slot per cycle while slots remain
	assign rd_en   = busy_q && (issue_q < count_q);
	assign rd_addr = issue_q[AW-1:0];

	// Single shared comparator on the registered read word
	assign hit = cmp_valid_s1 && (rd_data == rgb_q);

	assign rsp.done  = busy_q && (hit || !rd_en);
	assign rsp.color = hit ? COLOR_W'(cmp_idx_s1) : '0;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			issue_q      <= '0;
			cmp_valid_s1 <= 1'b0;
		end else if (start) begin
			busy_q       <= 1'b1;
			issue_q      <= '0;
			cmp_valid_s1 <= 1'b0;
		end else if (busy_q) begin
			if (rsp.done) begin
				busy_q <= 1'b0;
			end
			cmp_valid_s1 <= rd_en && !rsp.done;
			if (rd_en) begin
				issue_q <= issue_q + 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (start) begin
			rgb_q   <= rgb_value;
			count_q <= count;
		end
		cmp_idx_s1 <= issue_q[AW-1:0];
	end

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> busy_q)
		else $error("search done without active search");
	a_issue_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> issue_q <= count_q)
		else $error("search read past palette count");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && !start |=> !busy_q)
		else $error("search kept running after done");

endmodule

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import prle_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = PALETTE_DEPTH_DEF + 40;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PRINT_LIMIT    = 30;

	// DUT connections, all inputs known from time zero
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                kind = KIND_LOAD;
	logic [7:0]          entry_index = '0;
	logic [RGB_W-1:0]    rgb_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [LEN_W-1:0]    run_length;
	logic [COLOR_W-1:0]  color_number;
	logic                ends_row;
	logic                last;
	logic                cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ROW_WIDTH;
	logic [ROWW_W-1:0]   cfg_data = '0;

	// Encoder mirror: palette, open run, column and register copies
	logic [RGB_W-1:0]    pal_rgb [PALETTE_DEPTH_DEF];
	logic [COLOR_W-1:0]  run_color = '0;
	logic [15:0]         run_len = '0;
	logic [15:0]         col_pos = '0;
	logic [ROWW_W-1:0]   cfg_row_width = 13'd1;
	logic [PCOUNT_W-1:0] cfg_pal_count = '0;
	packet_t             packets_due [$];

	// Bookkeeping
	logic                steady = 1'b0;
	int unsigned         mismatches = 0;
	int unsigned         pixels_sent = 0;
	int unsigned         loads_sent = 0;
	int unsigned         packets_seen = 0;
	int unsigned         row_ends_seen = 0;
	int unsigned         full_runs_seen = 0;
	int unsigned         idle_cycles = 0;
	packet_t             want;

	palette_run_length_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.entry_index  (entry_index),
		.rgb_value    (rgb_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.run_length   (run_length),
		.color_number (color_number),
		.ends_row     (ends_row),
		.last         (last),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch on packet %0d: %s", $time, packets_seen, what);
		mismatches++;
	endtask

	// First matching slot among the searched ones, 0 when none matches
	function automatic logic [COLOR_W-1:0] match_color(input logic [RGB_W-1:0] rgb);
		int unsigned span;
		span = (cfg_pal_count > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : cfg_pal_count;
		for (int i = 0; i < span; i++)
			if (pal_rgb[i[7:0]] == rgb)
				return i[COLOR_W-1:0];
		return '0;
	endfunction

	function automatic packet_t make_packet(input logic [15:0] len,
		input logic [COLOR_W-1:0] color, input logic row_end);
		packet_t p;
		p.run_length   = len[LEN_W-1:0];
		p.color_number = color;
		p.ends_row     = row_end;
		p.last         = 1'b0;
		return p;
	endfunction

	// Advance the mirror by one accepted word and queue the packets it closes
	function automatic void encode_word(input logic k, input logic [7:0] slot,
		input logic [RGB_W-1:0] rgb);
		packet_t           made [2];
		int unsigned       n;
		int unsigned       width;
		logic [COLOR_W-1:0] idx;
		n = 0;
		if (k == KIND_LOAD) begin
			pal_rgb[slot] = rgb;
			loads_sent++;
			return;
		end
		pixels_sent++;
		width = (cfg_row_width == 0) ? 1 : cfg_row_width;
		if (width > MAX_ROW_WIDTH_DEF)
			width = MAX_ROW_WIDTH_DEF;
		idx = match_color(rgb);
		// color change closes the open run first
		if (run_len > 0 && idx != run_color) begin
			made[n] = make_packet(run_len, run_color, 1'b0);
			n++;
			run_len = 0;
		end
		if (run_len == 0)
			run_color = idx;
		run_len++;
		col_pos++;
		// row end wins over a full run
		if (col_pos >= width) begin
			made[n] = make_packet(run_len, run_color, 1'b1);
			n++;
			run_len = 0;
			col_pos = 0;
		end else if (run_len >= MAX_RUN_DEF) begin
			made[n] = make_packet(run_len, run_color, 1'b0);
			n++;
			run_len = 0;
		end
		if (n > 0)
			made[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			packets_due.push_back(made[i]);
	endfunction

	// Send one word, with random gaps ahead of it, and hold it until taken
	task automatic send_word(input logic k, input logic [7:0] slot, input logic [RGB_W-1:0] rgb);
		while (!steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		entry_index <= slot;
		rgb_value   <= rgb;
		do
			@(posedge clk);
		while (in_stall);
		encode_word(k, slot, rgb);
	endtask

	task automatic send_pixel(input logic [RGB_W-1:0] rgb);
		logic [7:0] junk;
		junk = 8'($urandom_range(255));
		send_word(KIND_PIXEL, junk, rgb);
	endtask

	// Drain all packets, then give a silent pixel time to finish its search
	task automatic settle();
		in_valid <= 1'b0;
		while (packets_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [ROWW_W-1:0] rw, input logic [PCOUNT_W-1:0] pc);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= REG_ROW_WIDTH;
		cfg_data  <= rw;
		@(posedge clk);
		cfg_row_width = rw;
		cfg_index <= REG_PALETTE_COUNT;
		cfg_data  <= {{(ROWW_W-PCOUNT_W){1'b0}}, pc};
		@(posedge clk);
		cfg_pal_count = pc;
		cfg_write <= 1'b0;
	endtask

	// Mostly palette colors near the searched range, some arbitrary ones
	function automatic logic [RGB_W-1:0] pick_color();
		int unsigned span;
		logic [RGB_W-1:0] shade;
		span = (cfg_pal_count > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : cfg_pal_count;
		shade = RGB_W'($urandom);
		if ($urandom_range(9) < 2)
			return shade;
		if (span == 0 || span == PALETTE_DEPTH_DEF)
			return pal_rgb[8'($urandom_range(PALETTE_DEPTH_DEF-1))];
		return pal_rgb[8'($urandom_range(span))];
	endfunction

	// Runs of random color and length, with palette rewrites and noise mixed in
	task automatic random_traffic(input int unsigned amount);
		int unsigned      sent;
		int unsigned      roll;
		int unsigned      len;
		logic [7:0]       slot;
		logic [RGB_W-1:0] shade;
		sent = 0;
		while (sent < amount) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				slot = 8'($urandom_range(255));
				shade = RGB_W'($urandom);
				if ($urandom_range(3) == 0)
					shade = pal_rgb[8'($urandom_range(PALETTE_DEPTH_DEF-1))];
				send_word(KIND_LOAD, slot, shade);
				sent++;
			end else if (roll < 13) begin
				shade = RGB_W'($urandom);
				send_pixel(shade);
				sent++;
			end else begin
				len = ($urandom_range(4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				shade = pick_color();
				repeat (len) send_pixel(shade);
				sent += len;
			end
		end
	endtask

	// Reset values: one-pixel rows, empty palette search
	task automatic test_reset_defaults();
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(RGB_W'($urandom));
	endtask

	// Fill every slot; a few repeat earlier colors so first-match order matters
	task automatic load_palette();
		logic [RGB_W-1:0] shade;
		for (int i = 0; i < PALETTE_DEPTH_DEF; i++) begin
			shade = RGB_W'($urandom);
			if (i == 3)
				shade = 24'h000000;
			else if (i == 5)
				shade = pal_rgb[1];
			else if (i == PALETTE_DEPTH_DEF - 1)
				shade = 24'hFFFFFF;
			else if (i > 8 && $urandom_range(7) == 0)
				shade = pal_rgb[8'($urandom_range(i - 1))];
			send_word(KIND_LOAD, i[7:0], shade);
		end
	endtask

	task automatic test_directed_runs();
		logic [RGB_W-1:0] a;
		logic [RGB_W-1:0] b;
		logic [RGB_W-1:0] stray;
		logic [RGB_W-1:0] shade;
		a = pal_rgb[0];
		b = pal_rgb[2];
		stray = RGB_W'($urandom);
		shade = RGB_W'($urandom);
		// color changes, duplicate entry, load inside a run, change at row end
		configure(13'd6, 9'd256);
		send_pixel(a);
		send_pixel(a);
		send_pixel(b);
		send_pixel(b);
		send_word(KIND_LOAD, 8'd200, shade);
		send_pixel(pal_rgb[5]);
		send_pixel(stray);
		send_pixel(24'hFFFFFF);
		send_pixel(24'hFFFFFF);
		repeat (4) send_pixel(24'h000000);
		// zero width acts as one, count past depth searches all
		configure(13'd0, 9'd511);
		send_pixel(a);
		send_pixel(b);
		// width past the maximum, then shrunk below the current column
		configure(13'd8191, 9'd1);
		send_pixel(a);
		send_pixel(a);
		send_pixel(a);
		send_pixel(b);
		configure(13'd2, 9'd1);
		send_pixel(a);
	endtask

	// Run that fills exactly at row end, then one split at the run limit
	task automatic test_long_runs();
		configure(13'd255, 9'd2);
		while (col_pos != 0)
			send_pixel(pal_rgb[0]);
		repeat (MAX_RUN_DEF) send_pixel(pal_rgb[1]);
		configure(13'd4096, 9'd3);
		repeat (300) send_pixel(pal_rgb[2]);
		repeat (40) send_pixel(pal_rgb[0]);
	endtask

	task automatic test_random_mix();
		logic [ROWW_W-1:0]   rw;
		logic [PCOUNT_W-1:0] pc;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(9))
				0:       rw = 13'd0;
				1:       rw = 13'd1;
				7:       rw = ROWW_W'($urandom_range(25, 300));
				8:       rw = 13'd4096;
				9:       rw = ROWW_W'($urandom_range(4097, 8191));
				default: rw = ROWW_W'($urandom_range(2, 24));
			endcase
			case ($urandom_range(9))
				0:       pc = 9'd0;
				7:       pc = PCOUNT_W'($urandom_range(17, 255));
				8:       pc = 9'd256;
				9:       pc = PCOUNT_W'($urandom_range(257, 511));
				default: pc = PCOUNT_W'($urandom_range(1, 16));
			endcase
			configure(rw, pc);
			random_traffic(70);
		end
	endtask

	// Back-to-back traffic with neither side pausing
	task automatic test_steady_stream();
		logic [ROWW_W-1:0]   rw;
		logic [PCOUNT_W-1:0] pc;
		rw = ROWW_W'($urandom_range(3, 12));
		pc = PCOUNT_W'($urandom_range(1, 8));
		configure(rw, pc);
		steady = 1'b1;
		random_traffic(160);
		settle();
		steady = 1'b0;
	endtask

	// Output side stalls at random except during the steady stretch
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 23);
	end

	// Compare each packet taken with the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (packets_due.size() == 0) begin
				report_mismatch("packet with nothing due");
			end else begin
				want = packets_due.pop_front();
				if (run_length !== want.run_length)
					report_mismatch($sformatf("run_length %0d, due %0d", run_length,
						want.run_length));
				if (color_number !== want.color_number)
					report_mismatch($sformatf("color_number %0d, due %0d", color_number,
						want.color_number));
				if (ends_row !== want.ends_row)
					report_mismatch($sformatf("ends_row %0b, due %0b", ends_row, want.ends_row));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, due %0b", last, want.last));
			end
			if (ends_row === 1'b1)
				row_ends_seen++;
			if (run_length === LEN_W'(MAX_RUN_DEF))
				full_runs_seen++;
			packets_seen++;
		end
	end

	// Watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no word moved for %0d cycles, %0d packets still due", $time,
				idle_cycles, packets_due.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		load_palette();
		test_directed_runs();
		test_long_runs();
		test_random_mix();
		test_steady_stream();
		settle();
		$display("sent %0d pixels and %0d palette loads; checked %0d packets", pixels_sent,
			loads_sent, packets_seen);
		$display("%0d packets closed a row, %0d hit the run limit, %0d mismatches",
			row_ends_seen, full_runs_seen, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/prle_pkg.sv
rtl/prle_ram.sv
rtl/prle_search.sv
rtl/palette_run_length_encoder.sv
sim/tb_top.sv
